[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[design/sjf_pkg.sv]
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and constants shared by the task order scheduler and its cells.
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int VAL_W = 32;
    localparam int CLK_W = 40;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] ready_rt;
        logic [IDX_W-1:0] ready_idx;
        logic             any;
        logic [VAL_W-1:0] min_arr;
        logic [VAL_W-1:0] min_rt;
        logic [IDX_W-1:0] min_idx;
    } rec_t;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic [VAL_W-1:0] load_arr;
        logic [VAL_W-1:0] load_rt;
        logic             mark;
        logic [IDX_W-1:0] mark_idx;
        logic             clear;
    } cell_ctl_t;

endpackage

[design/shortest_job_first_task_order.sv]
// ----------------------------------------------------------------------------
// shortest_job_first_task_order
// Loads a batch of tasks and emits their indices in shortest-job-first order.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                               tlast        tuser
// s_axis    in   enqueue_time, process_time          last_task    -
// m_axis    out  task_index (padded to 8 bits)       last_result  dropped_tasks
//
// Tasks are loaded one per cycle. For each result after the last task, a search
// record walks the row of cells, one cell per cycle. Input is stalled from the
// last task until the final result transfer.
// Reset clears the batch count, valid and done marks; task stores are not reset.
// ----------------------------------------------------------------------------
module shortest_job_first_task_order
    import sjf_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // enqueue_time[31:0], process_time[63:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // task_index[5:0], zero[7:6]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // dropped_tasks[0]
);

    localparam int SW = (TIME_BITS < VAL_W) ? TIME_BITS : VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             ovf_reg, ovf_next;
    logic [CLK_W-1:0] time_reg, time_next;
    logic             start_reg, start_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_reg, last_next;
    cell_ctl_t        ctl;
    logic             tok [MAX_TASKS+1];
    rec_t             rec [MAX_TASKS+1];
    rec_t             fin;
    logic             s_xfer;
    logic             m_xfer;
    logic             has_room;
    logic [IDX_W-1:0] pick;
    logic [VAL_W-1:0] pick_rt;
    logic [CLK_W-1:0] base;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {2'b00, idx_reg};
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = ovf_reg;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign m_xfer   = m_axis_tvalid && m_axis_tready;
    assign has_room = count_reg < CNT_W'(MAX_TASKS);
    assign fin      = rec[MAX_TASKS];
    assign pick     = fin.found ? fin.ready_idx : fin.min_idx;
    assign pick_rt  = fin.found ? fin.ready_rt : fin.min_rt;
    assign base     = fin.found ? time_reg : CLK_W'(fin.min_arr);

    assign tok[0] = start_reg;
    assign rec[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            sjf_cell #(.SW(SW), .IDX(g)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .now     (time_reg),
                .tok_in  (tok[g]),
                .rec_in  (rec[g]),
                .tok_out (tok[g+1]),
                .rec_out (rec[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        emit_next    = emit_reg;
        ovf_next     = ovf_reg;
        time_next    = time_reg;
        start_next   = 1'b0;
        idx_next     = idx_reg;
        last_next    = last_reg;
        ctl          = '0;
        ctl.load_idx = count_reg[IDX_W-1:0];
        ctl.load_arr = s_axis_tdata[31:0] & VAL_W'({SW{1'b1}});
        ctl.load_rt  = s_axis_tdata[63:32] & VAL_W'({SW{1'b1}});
        ctl.mark_idx = pick;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (has_room)
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_SWEEP;
                        start_next = 1'b1;
                        time_next  = '0;
                        emit_next  = '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (tok[MAX_TASKS])
                begin
                    ctl.mark   = 1'b1;
                    idx_next   = pick;
                    last_next  = (emit_reg + 1'b1) == count_reg;
                    time_next  = base + CLK_W'(pick_rt);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_xfer)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (last_reg)
                    begin
                        ctl.clear  = 1'b1;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        time_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_SWEEP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            emit_reg  <= '0;
            ovf_reg   <= 1'b0;
            time_reg  <= '0;
            start_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            emit_reg  <= emit_next;
            ovf_reg   <= ovf_next;
            time_reg  <= time_next;
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

endmodule

[design/sjf_cell.sv]
// ----------------------------------------------------------------------------
// sjf_cell
// One task slot; folds its task into the search record passing through.
// ----------------------------------------------------------------------------
module sjf_cell
    import sjf_pkg::*;
#(
    parameter int SW  = 32,
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [CLK_W-1:0] now,
    input  logic             tok_in,
    input  rec_t             rec_in,
    output logic             tok_out,
    output rec_t             rec_out
);

    logic [SW-1:0] arr_reg;
    logic [SW-1:0] rt_reg;
    logic          valid_reg;
    logic          done_reg;
    logic          tok_reg;
    rec_t          rec_reg;
    rec_t          rec_next;
    logic          pend;
    logic          rdy;
    logic [VAL_W-1:0] arr_x;
    logic [VAL_W-1:0] rt_x;

    assign arr_x = VAL_W'(arr_reg);
    assign rt_x  = VAL_W'(rt_reg);
    assign pend  = valid_reg && !done_reg;
    assign rdy   = pend && (CLK_W'(arr_x) <= now);

    always_comb
    begin
        rec_next = rec_in;
        if (rdy && (!rec_in.found || rt_x < rec_in.ready_rt))
        begin
            rec_next.found     = 1'b1;
            rec_next.ready_rt  = rt_x;
            rec_next.ready_idx = IDX_W'(IDX);
        end
        if (pend && (!rec_in.any || arr_x < rec_in.min_arr ||
                     (arr_x == rec_in.min_arr && rt_x < rec_in.min_rt)))
        begin
            rec_next.any     = 1'b1;
            rec_next.min_arr = arr_x;
            rec_next.min_rt  = rt_x;
            rec_next.min_idx = IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.load_idx == IDX_W'(IDX))
        begin
            arr_reg <= ctl.load_arr[SW-1:0];
            rt_reg  <= ctl.load_rt[SW-1:0];
        end
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (ctl.clear)
            begin
                valid_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            else if (ctl.load && ctl.load_idx == IDX_W'(IDX))
            begin
                valid_reg <= 1'b1;
                done_reg  <= 1'b0;
            end
            else if (ctl.mark && ctl.mark_idx == IDX_W'(IDX))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign tok_out = tok_reg;
    assign rec_out = rec_reg;

endmodule

[design/sjf_checker.sv]
// ----------------------------------------------------------------------------
// sjf_checker
// Port-level checks of the task order scheduler, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sjf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_SAME(a_no_load_in_emit, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    `ASSERT_NEXT(a_last_in_stalls, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    `ASSERT_NEXT(a_last_out_frees, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready)

endmodule

bind shortest_job_first_task_order sjf_checker u_sjf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
